// ===== hdl/time_bucket_downsampler_assert.svh =====
`ifndef TIME_BUCKET_DOWNSAMPLER_ASSERT_SVH
`define TIME_BUCKET_DOWNSAMPLER_ASSERT_SVH
// Same-cycle implication, checked outside reset.
`define TBD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define TBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/tbd_pkg.sv =====
package tbd_pkg;

  localparam int TIME_BITS = 48;
  localparam int IV_BITS   = 40;
  localparam int VAL_BITS  = 32;
  localparam int RES_BITS  = 48;
  localparam int SUM_BITS  = 64;
  localparam int CNT_BITS  = 32;
  localparam int FILL_W    = 6;
  localparam logic [FILL_W-1:0] FILL_MAX = 6'd63;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AGG      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILL     = 3'd4;

  // Aggregate function codes
  localparam logic [2:0] AGG_SUM   = 3'd0;
  localparam logic [2:0] AGG_COUNT = 3'd1;
  localparam logic [2:0] AGG_MIN   = 3'd2;
  localparam logic [2:0] AGG_MAX   = 3'd3;
  localparam logic [2:0] AGG_FIRST = 3'd4;
  localparam logic [2:0] AGG_LAST  = 3'd5;
  localparam logic [2:0] AGG_AVG   = 3'd6;

  // Fill policy codes
  localparam logic [1:0] FILL_NONE = 2'd0;
  localparam logic [1:0] FILL_NAN  = 2'd1;
  localparam logic [1:0] FILL_NULL = 2'd2;
  localparam logic [1:0] FILL_ZERO = 2'd3;

  // Input command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic                       cmd;
    logic [TIME_BITS-1:0]       sample_time;
    logic signed [VAL_BITS-1:0] sample_value;
  } tbd_item_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]       bucket_time;
    logic signed [RES_BITS-1:0] result_value;
    logic                       is_fill;
    logic                       is_missing;
    logic                       fill_truncated;
    logic                       last_of_run;
  } tbd_result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tbd_div_stat_t;

endpackage

// ===== hdl/time_bucket_downsampler.sv =====
// Time bucket downsampler.
// item channel (item_valid/item_ready/item): a sample (cmd 0) or a finish (cmd 1).
// Samples are floored to a bucket and folded into the open bucket's aggregate.
// A sample that opens a new bucket emits the previous result, then gap fill
// points; a finish emits the open bucket, fills to range_end and clears state.
// result channel (result_valid/result_ready/result): one registered output slot.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write only
// while no item is in flight.
// Flow: one item at a time. A sample is floored by one 64-step pass of the
// shared restoring divider, as is range_start when no bucket is open; a finish
// with an open bucket skips that pass. A new bucket with average adds a second
// pass. The fill run is counted first (one point per cycle, at most 63), then
// each output leaves through the output slot in turn. item_ready is high only
// while the sequencer idles.
// A stalled receiver holds the output slot and the sequencer waits on it.
// Reset (rst, synchronous) clears the bucket state and restores the registers
// to interval 60, range 0..0, sum, no fill.
module time_bucket_downsampler
  import tbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  tbd_item_t             item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output tbd_result_t           result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MOD_T, ST_DECIDE, ST_MOD_RS, ST_RES, ST_AVG,
    ST_FILLSET, ST_COUNT, ST_EMIT
  } state_t;

  state_t state;

  // Configuration
  logic [IV_BITS-1:0]   bucket_interval;
  logic [TIME_BITS-1:0] range_start, range_end;
  logic [2:0]           agg_function;
  logic [1:0]           fill_policy;

  // Bucket state
  logic [TIME_BITS-1:0]       held_bucket;
  logic                       bucket_open;
  logic signed [SUM_BITS-1:0] running_sum;
  logic [CNT_BITS-1:0]        sample_count;
  logic signed [VAL_BITS-1:0] held_value;

  // Working registers
  logic                       cmd_r;
  logic [TIME_BITS-1:0]       t_r, b_r, lim, res_time;
  logic signed [VAL_BITS-1:0] v_r;
  logic signed [RES_BITS-1:0] res_val;
  logic                       have_res, fill_en, incl, trunc, avg_neg;
  logic [TIME_BITS:0]         s0, scan;
  logic [FILL_W-1:0]          k, fill_cnt;

  // Divider interface
  logic                div_start;
  logic [SUM_BITS-1:0] div_a;
  logic [IV_BITS-1:0]  div_b;
  tbd_div_stat_t       div_stat;
  logic [SUM_BITS-1:0] div_q;
  logic [IV_BITS-1:0]  div_r;

  tbd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .stat      (div_stat),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Derived values
  logic [IV_BITS-1:0]       iv;
  logic [TIME_BITS:0]       scan_next, held_next, fs_up;
  logic [TIME_BITS-1:0]     fs;
  logic                     cond;
  logic signed [SUM_BITS:0] sum_add;
  logic signed [SUM_BITS-1:0] sum_sat;
  logic [SUM_BITS-1:0]      sum_mag;
  logic signed [SUM_BITS:0] plain_res, avg_res;
  logic                     missing;

  function automatic logic signed [RES_BITS-1:0] sat48(input logic signed [SUM_BITS:0] x);
    logic signed [SUM_BITS:0] hi, lo;
    hi = (SUM_BITS+1)'(signed'({1'b0, {(RES_BITS-1){1'b1}}}));
    lo = -hi - (SUM_BITS+1)'(1);
    if (x > hi) return hi[RES_BITS-1:0];
    if (x < lo) return lo[RES_BITS-1:0];
    return x[RES_BITS-1:0];
  endfunction

  assign iv        = (bucket_interval == '0) ? IV_BITS'(1) : bucket_interval;
  assign scan_next = scan + {9'd0, iv};
  assign held_next = {1'b0, held_bucket} + {9'd0, iv};
  assign fs        = range_start - TIME_BITS'(div_r);
  assign fs_up     = {1'b0, fs} + {9'd0, iv};
  assign cond      = incl ? (scan <= {1'b0, lim}) : (scan < {1'b0, lim});
  assign missing   = (fill_policy == FILL_NAN) || (fill_policy == FILL_NULL);

  // Saturating add of the sample into the running sum
  assign sum_add = {running_sum[SUM_BITS-1], running_sum} + (SUM_BITS+1)'(v_r);
  always_comb begin
    if (sum_add[SUM_BITS] != sum_add[SUM_BITS-1]) begin
      sum_sat = sum_add[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                  : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      sum_sat = sum_add[SUM_BITS-1:0];
    end
  end

  assign sum_mag = running_sum[SUM_BITS-1] ? SUM_BITS'(-running_sum) : running_sum;
  assign avg_res = avg_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

  // Result of the held bucket, other than the average
  always_comb begin
    case (agg_function) inside
      AGG_COUNT: plain_res = $signed({33'd0, sample_count});
      AGG_MIN, AGG_MAX, AGG_FIRST, AGG_LAST: plain_res = (SUM_BITS+1)'(held_value);
      AGG_AVG: plain_res = '0;
      default: plain_res = (SUM_BITS+1)'(running_sum);
    endcase
  end

  assign item_ready = (state == ST_IDLE);
  assign cfg_ready  = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_interval <= IV_BITS'(60);
      range_start     <= '0;
      range_end       <= '0;
      agg_function    <= AGG_SUM;
      fill_policy     <= FILL_NONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_INTERVAL: bucket_interval <= cfg_data[IV_BITS-1:0];
        REG_START:    range_start     <= cfg_data[TIME_BITS-1:0];
        REG_END:      range_end       <= cfg_data[TIME_BITS-1:0];
        REG_AGG:      agg_function    <= cfg_data[2:0];
        REG_FILL:     fill_policy     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, bucket state and output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      held_bucket  <= '0;
      bucket_open  <= 1'b0;
      running_sum  <= '0;
      sample_count <= '0;
      held_value   <= '0;
      result_valid <= 1'b0;
      div_start    <= 1'b0;
      have_res     <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (result_ready) result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            cmd_r <= item.cmd;
            t_r   <= item.sample_time;
            v_r   <= item.sample_value;
            div_b <= iv;
            div_start <= (item.cmd != CMD_FINISH) || !bucket_open;
            have_res  <= 1'b0;
            if (item.cmd == CMD_FINISH) begin
              div_a <= SUM_BITS'(range_start);
              state <= bucket_open ? ST_RES : ST_MOD_RS;
            end else begin
              div_a <= SUM_BITS'(item.sample_time);
              state <= ST_MOD_T;
            end
          end
        end
        ST_MOD_T: begin
          if (div_stat.done) begin
            b_r   <= t_r - TIME_BITS'(div_r);
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (b_r < range_start || (bucket_open && b_r < held_bucket)) begin
            state <= ST_IDLE;
          end else if (bucket_open && b_r == held_bucket) begin
            // Fold the sample into the open bucket
            if (sample_count != '1) sample_count <= sample_count + CNT_BITS'(1);
            running_sum <= sum_sat;
            if (agg_function == AGG_MIN && v_r < held_value) held_value <= v_r;
            if (agg_function == AGG_MAX && v_r > held_value) held_value <= v_r;
            if (agg_function == AGG_LAST) held_value <= v_r;
            state <= ST_IDLE;
          end else if (bucket_open) begin
            state <= ST_RES;
          end else begin
            div_a     <= SUM_BITS'(range_start);
            div_b     <= iv;
            div_start <= 1'b1;
            state     <= ST_MOD_RS;
          end
        end
        ST_MOD_RS: begin
          if (div_stat.done) begin
            // Fill start: range start floored, rounded up to it
            s0      <= (fs < range_start) ? fs_up : {1'b0, fs};
            scan    <= (fs < range_start) ? fs_up : {1'b0, fs};
            lim     <= (cmd_r == CMD_FINISH) ? range_end : b_r;
            incl    <= (cmd_r == CMD_FINISH);
            fill_en <= (fill_policy != FILL_NONE);
            k       <= '0;
            trunc   <= 1'b0;
            state   <= ST_COUNT;
          end
        end
        ST_RES: begin
          if (agg_function == AGG_AVG && sample_count != '0) begin
            div_a     <= sum_mag;
            div_b     <= IV_BITS'(sample_count);
            avg_neg   <= running_sum[SUM_BITS-1];
            div_start <= 1'b1;
            state     <= ST_AVG;
          end else begin
            res_val <= sat48(plain_res);
            state   <= ST_FILLSET;
          end
        end
        ST_AVG: begin
          if (div_stat.done) begin
            res_val <= sat48(avg_res);
            state   <= ST_FILLSET;
          end
        end
        ST_FILLSET: begin
          have_res <= 1'b1;
          res_time <= held_bucket;
          s0       <= held_next;
          scan     <= held_next;
          lim      <= (cmd_r == CMD_FINISH) ? range_end : b_r;
          incl     <= (cmd_r == CMD_FINISH);
          fill_en  <= (fill_policy != FILL_NONE) && !held_next[TIME_BITS];
          k        <= '0;
          trunc    <= 1'b0;
          state    <= ST_COUNT;
        end
        ST_COUNT: begin
          // Count the fill run ahead so a capped run is flagged throughout
          if (!fill_en || !cond || k == FILL_MAX || scan_next[TIME_BITS]) begin
            if (fill_en && cond && k == FILL_MAX) begin
              trunc    <= 1'b1;
              fill_cnt <= k;
            end else if (fill_en && cond) begin
              fill_cnt <= k + FILL_W'(1);
            end else begin
              fill_cnt <= k;
            end
            scan <= s0;
            // Update the bucket state; the result is already captured
            if (cmd_r == CMD_FINISH) begin
              held_bucket  <= '0;
              bucket_open  <= 1'b0;
              running_sum  <= '0;
              sample_count <= '0;
              held_value   <= '0;
            end else begin
              held_bucket  <= b_r;
              bucket_open  <= 1'b1;
              running_sum  <= SUM_BITS'(v_r);
              sample_count <= CNT_BITS'(1);
              held_value   <= v_r;
            end
            state <= ST_EMIT;
          end else begin
            k    <= k + FILL_W'(1);
            scan <= scan_next;
          end
        end
        ST_EMIT: begin
          if (!have_res && fill_cnt == '0) begin
            state <= ST_IDLE;
          end else if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            if (have_res) begin
              result.bucket_time    <= res_time;
              result.result_value   <= res_val;
              result.is_fill        <= 1'b0;
              result.is_missing     <= 1'b0;
              result.fill_truncated <= 1'b0;
              result.last_of_run    <= (fill_cnt == '0);
              have_res <= 1'b0;
              if (fill_cnt == '0) state <= ST_IDLE;
            end else begin
              result.bucket_time    <= scan[TIME_BITS-1:0];
              result.result_value   <= '0;
              result.is_fill        <= 1'b1;
              result.is_missing     <= missing;
              result.fill_truncated <= trunc;
              result.last_of_run    <= (fill_cnt == FILL_W'(1));
              scan     <= scan_next;
              fill_cnt <= fill_cnt - FILL_W'(1);
              if (fill_cnt == FILL_W'(1)) state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/tbd_div.sv =====
module tbd_div
  import tbd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SUM_BITS-1:0] dividend,
  input  logic [IV_BITS-1:0]  divisor,
  output tbd_div_stat_t       stat,
  output logic [SUM_BITS-1:0] quotient,
  output logic [IV_BITS-1:0]  remainder
);

  logic [IV_BITS-1:0] dvs;
  logic [5:0]         cnt;
  logic [IV_BITS:0]   shifted;
  logic               take;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign shifted = {remainder, quotient[SUM_BITS-1]};
  assign take    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= 6'd63;
        remainder <= '0;
        quotient  <= dividend;
        dvs       <= divisor;
      end else if (stat.busy) begin
        if (take) begin
          remainder <= IV_BITS'(shifted - {1'b0, dvs});
        end else begin
          remainder <= shifted[IV_BITS-1:0];
        end
        quotient <= {quotient[SUM_BITS-2:0], take};
        cnt      <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/tbd_checker.sv =====
`include "time_bucket_downsampler_assert.svh"

module tbd_checker
  import tbd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input tbd_result_t result,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // Hold a stalled result
  `TBD_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result))
  // Drop ready after each item transfer
  `TBD_ASSERT_NEXT(a_busy_after_item, clk, rst, item_valid && item_ready, !item_ready)
  // Take every configuration write
  `TBD_ASSERT_NOW(a_cfg_ready, clk, rst, cfg_valid, cfg_ready)
  // Real points carry no fill flags
  `TBD_ASSERT_NOW(a_real_flags, clk, rst, result_valid && !result.is_fill, !result.is_missing && !result.fill_truncated)

endmodule

bind time_bucket_downsampler tbd_checker u_tbd_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);
